@@ sv/ptsc_pkg.sv @@
// Shared types, codes and helpers for the priority thread scheduler.
package ptsc_pkg;

	localparam int DEF_THREAD_SLOTS = 8;

	localparam logic [1:0] ERR_OK     = 2'd0;
	localparam logic [1:0] ERR_FULL   = 2'd1;
	localparam logic [1:0] ERR_TARGET = 2'd2;

	typedef enum logic [2:0] {
		CMD_CREATE  = 3'd0,
		CMD_START   = 3'd1,
		CMD_TICK    = 3'd2,
		CMD_SUSPEND = 3'd3,
		CMD_BLOCK   = 3'd4,
		CMD_RESUME  = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_UNUSED    = 3'd0,
		ST_READY     = 3'd1,
		ST_RUNNING   = 3'd2,
		ST_SUSPENDED = 3'd3,
		ST_BLOCKED   = 3'd4
	} thread_st_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FIN
	} seq_st_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [7:0]  priority_req;
		logic [31:0] delay_ticks;
		logic [2:0]  target_slot;
	} in_item_t;

	typedef struct packed {
		logic [3:0] running_slot;
		logic [2:0] created_slot;
		logic [1:0] error_code;
	} out_item_t;

	typedef struct packed {
		thread_st_t  status;
		logic [7:0]  prio;
		logic [31:0] wake;
	} slot_rd_t;

	typedef struct packed {
		logic        st_we;
		thread_st_t  status;
		logic        prio_we;
		logic [7:0]  prio;
		logic        wake_we;
		logic [31:0] wake;
	} slot_wr_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic        is_cur;
		logic        is_tgt;
		logic        is_new;
		logic [31:0] tick;
		logic [31:0] delay;
		logic [7:0]  top;
	} eval_ctx_t;

	typedef struct packed {
		thread_st_t  status;
		logic        st_we;
		logic        prio_we;
		logic        wake_we;
		logic [31:0] wake;
		logic        cand;
		logic        tgt_bad;
	} eval_res_t;

	function automatic logic is_resched(input logic [2:0] cmd, input logic [31:0] delay);
		return (cmd == CMD_TICK) || ((cmd == CMD_SUSPEND) && (delay != 32'd0));
	endfunction

	function automatic logic is_pick(input logic [2:0] cmd, input logic [31:0] delay);
		return is_resched(cmd, delay) || (cmd == CMD_START);
	endfunction

endpackage

@@ sv/ptsc_slot_table.sv @@
// Thread slot table: status, priority and wake time per slot, one read and one write port.
module ptsc_slot_table #(
	parameter int THREAD_SLOTS = ptsc_pkg::DEF_THREAD_SLOTS,
	parameter int IW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [IW-1:0]      rd_addr,
	output ptsc_pkg::slot_rd_t rd,
	input  logic [IW-1:0]      wr_addr,
	input  ptsc_pkg::slot_wr_t wr
);
	import ptsc_pkg::*;

	thread_st_t  status_q [THREAD_SLOTS];
	logic [7:0]  prio_q   [THREAD_SLOTS];
	logic [31:0] wake_q   [THREAD_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < THREAD_SLOTS; i++) begin
				status_q[i] <= ST_UNUSED;
				prio_q[i]   <= 8'd0;
			end
		end else begin
			if (wr.st_we)
				status_q[wr_addr] <= wr.status;
			if (wr.prio_we)
				prio_q[wr_addr] <= wr.prio;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.wake_we)
			wake_q[wr_addr] <= wr.wake;
	end

	assign rd.status = status_q[rd_addr];
	assign rd.prio   = prio_q[rd_addr];
	assign rd.wake   = wake_q[rd_addr];

endmodule

@@ sv/ptsc_slot_eval.sv @@
// Per-slot update unit: new status, wake time and priority candidate for one slot per cycle.
module ptsc_slot_eval (
	input  ptsc_pkg::slot_rd_t  rd,
	input  ptsc_pkg::eval_ctx_t ctx,
	output ptsc_pkg::eval_res_t res
);
	import ptsc_pkg::*;

	logic resched;
	logic pick;

	always_comb begin
		resched     = is_resched(ctx.cmd, ctx.delay);
		pick        = is_pick(ctx.cmd, ctx.delay);
		res.status  = rd.status;
		res.st_we   = 1'b0;
		res.prio_we = 1'b0;
		res.wake_we = 1'b0;
		res.wake    = ctx.tick + ctx.delay;
		res.cand    = 1'b0;
		res.tgt_bad = 1'b0;
		case (ctx.cmd)
			CMD_CREATE: begin
				if (ctx.is_new) begin
					res.status  = ST_READY;
					res.st_we   = 1'b1;
					res.prio_we = 1'b1;
				end
			end
			CMD_BLOCK: begin
				if (ctx.is_tgt) begin
					if (rd.status == ST_UNUSED) begin
						res.tgt_bad = 1'b1;
					end else begin
						res.status = ST_BLOCKED;
						res.st_we  = 1'b1;
					end
				end
			end
			CMD_RESUME: begin
				if (ctx.is_tgt) begin
					if (rd.status == ST_UNUSED) begin
						res.tgt_bad = 1'b1;
					end else if (rd.status != ST_RUNNING) begin
						res.status = ST_READY;
						res.st_we  = 1'b1;
					end
				end
			end
			default: begin
				if (pick) begin
					res.st_we = 1'b1;
					if ((ctx.cmd == CMD_SUSPEND) && resched && ctx.is_cur
							&& (rd.status == ST_RUNNING)) begin
						res.status  = ST_SUSPENDED;
						res.wake_we = 1'b1;
					end else if (resched && (rd.status == ST_SUSPENDED)
							&& (rd.wake == ctx.tick)) begin
						res.status = ST_READY;
					end else if (ctx.is_cur && (rd.status == ST_RUNNING)) begin
						res.status = ST_READY;
					end
					res.cand = (res.status == ST_READY) && (rd.prio > ctx.top);
				end
			end
		endcase
	end

endmodule

@@ sv/priority_thread_scheduler_core.sv @@
// Priority thread scheduler top level: command sequencer, slot scan and response register.
//
//  channel | signals                        | beat
//  --------+--------------------------------+--------------------------------
//  cmd     | cmd_valid cmd_ready cmd_data   | one command: op, priority, delay, slot
//  rsp     | rsp_valid rsp_ready rsp_data   | running slot, created slot, error
//
// Each command is accepted, then each slot in turn passes through the shared slot update
// unit, and finally the selection is committed.
// Reset clears all slots to unused, tick and slot count to zero, running to idle.
// A finished response waits in its register; the next command is accepted meanwhile,
// and the commit cycle stalls only while an earlier response is still untaken.
module priority_thread_scheduler_core #(
	parameter int THREAD_SLOTS = ptsc_pkg::DEF_THREAD_SLOTS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  ptsc_pkg::in_item_t  cmd_data,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output ptsc_pkg::out_item_t rsp_data
);
	import ptsc_pkg::*;

	localparam int IW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
	localparam int CW = $clog2(THREAD_SLOTS + 1);
	localparam logic [IW-1:0] LAST = IW'(THREAD_SLOTS - 1);
	localparam logic [CW-1:0] IDLE = CW'(THREAD_SLOTS);

	seq_st_t     state_q, state_d;
	in_item_t    cmd_q;
	logic [IW-1:0] idx_q;
	logic [CW-1:0] best_q;
	logic [7:0]  top_q;
	logic        tgt_bad_q;
	logic [31:0] tick_q;
	logic [CW-1:0] used_q;
	logic [CW-1:0] cur_q;
	out_item_t   rsp_q;
	logic        rsp_valid_q;

	logic        accept;
	logic        fin_go;
	logic        pick;
	logic        resched;
	logic [CW-1:0] fin_cur;
	logic [1:0]  fin_err;
	logic [2:0]  fin_created;
	logic        fin_new;

	slot_rd_t    rd;
	slot_wr_t    wr;
	logic [IW-1:0] wr_addr;
	eval_ctx_t   ctx;
	eval_res_t   res;

	ptsc_slot_table #(
		.THREAD_SLOTS(THREAD_SLOTS),
		.IW(IW)
	) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.rd_addr(idx_q),
		.rd(rd),
		.wr_addr(wr_addr),
		.wr(wr)
	);

	ptsc_slot_eval u_eval (
		.rd(rd),
		.ctx(ctx),
		.res(res)
	);

	always_comb begin
		ctx.cmd    = cmd_q.command;
		ctx.is_cur = (CW'(idx_q) == cur_q);
		ctx.is_tgt = (5'(idx_q) == 5'(cmd_q.target_slot));
		ctx.is_new = (CW'(idx_q) == used_q);
		ctx.tick   = tick_q;
		ctx.delay  = cmd_q.delay_ticks;
		ctx.top    = top_q;
	end

	always_comb begin
		pick    = is_pick(cmd_q.command, cmd_q.delay_ticks);
		resched = is_resched(cmd_q.command, cmd_q.delay_ticks);
		fin_cur = pick ? best_q : cur_q;
		fin_new = (cmd_q.command == CMD_CREATE) && (used_q < IDLE);
		fin_created = fin_new ? 3'(used_q) : 3'd0;
		case (cmd_q.command)
			CMD_CREATE:
				fin_err = fin_new ? ERR_OK : ERR_FULL;
			CMD_BLOCK, CMD_RESUME:
				fin_err = ((int'(cmd_q.target_slot) >= THREAD_SLOTS) || tgt_bad_q)
					? ERR_TARGET : ERR_OK;
			default:
				fin_err = ERR_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		cmd_ready  = 1'b0;
		fin_go     = 1'b0;
		wr_addr    = idx_q;
		wr.st_we   = 1'b0;
		wr.status  = res.status;
		wr.prio_we = 1'b0;
		wr.prio    = cmd_q.priority_req;
		wr.wake_we = 1'b0;
		wr.wake    = res.wake;
		case (state_q)
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid)
					state_d = S_SCAN;
			end
			S_SCAN: begin
				wr.st_we   = res.st_we;
				wr.prio_we = res.prio_we;
				wr.wake_we = res.wake_we;
				if (idx_q == LAST)
					state_d = S_FIN;
			end
			S_FIN: begin
				fin_go = !rsp_valid_q || rsp_ready;
				if (fin_go) begin
					state_d = S_IDLE;
					if (pick && (best_q != IDLE)) begin
						wr_addr   = best_q[IW-1:0];
						wr.st_we  = 1'b1;
						wr.status = ST_RUNNING;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign accept = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q       <= '0;
			idx_q       <= '0;
			best_q      <= IDLE;
			top_q       <= 8'd0;
			tgt_bad_q   <= 1'b0;
			tick_q      <= 32'd0;
			used_q      <= '0;
			cur_q       <= IDLE;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cmd_q     <= cmd_data;
				idx_q     <= '0;
				best_q    <= IDLE;
				top_q     <= 8'd0;
				tgt_bad_q <= 1'b0;
			end
			if (state_q == S_SCAN) begin
				if (idx_q != LAST)
					idx_q <= idx_q + 1'b1;
				if (res.cand) begin
					best_q <= CW'(idx_q);
					top_q  <= rd.prio;
				end
				if (res.tgt_bad)
					tgt_bad_q <= 1'b1;
			end
			if (fin_go) begin
				cur_q <= fin_cur;
				if (resched)
					tick_q <= tick_q + 32'd1;
				if (fin_new)
					used_q <= used_q + 1'b1;
				rsp_q.running_slot <= 4'(fin_cur);
				rsp_q.created_slot <= fin_created;
				rsp_q.error_code   <= fin_err;
				rsp_valid_q        <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

`ifndef SYNTH
	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_FIN))
		else $error("response raised outside commit");

	a_tick_at_fin: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(tick_q) |-> $past(state_q == S_FIN))
		else $error("tick counter moved outside commit");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= IDLE)
		else $error("slot count beyond table size");

	a_cur_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= IDLE)
		else $error("running slot out of range");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !cmd_ready)
		else $error("command taken during scan");
`endif

endmodule
